### design/wsd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the WebSocket client frame deframer.
// No dependencies; used by the parser, the result queue, the top level and the checker.
package wsd_pkg;

    // Default sizes
    localparam int unsigned MAX_MESSAGE_DEF = 1024;
    localparam int unsigned MAX_CONTROL_DEF = 125;

    // Result queue sizing
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Frame opcodes
    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    // Extended length codes of the second header byte
    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;

    // Result kinds
    typedef enum logic [2:0] {
        K_DATA       = 3'd0,
        K_COMMIT     = 3'd1,
        K_PONG_BYTE  = 3'd2,
        K_PONG_SEND  = 3'd3,
        K_CLOSE      = 3'd4,
        K_CLOSE_1009 = 3'd5,
        K_ABORT      = 3'd6
    } t_kind;

    // Parser phase, one-hot
    typedef enum logic [4:0] {
        PH_FIRST   = 5'b00001,
        PH_SECOND  = 5'b00010,
        PH_EXTLEN  = 5'b00100,
        PH_MASK    = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } t_phase;

    // One result item
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data_byte;
        logic       last_of_run;
    } t_result;

    // Results caused by one received byte (count 0..2)
    typedef struct packed {
        logic [1:0] count;
        t_result    r0;
        t_result    r1;
    } t_burst;

endpackage

### design/wsd_parser.sv
`timescale 1ns / 1ps
// Frame header parser, unmasker and message tracker: one accepted byte per cycle.
// Depends on wsd_pkg; feeds the burst of results to wsd_out_queue.
module wsd_parser #(
    parameter int unsigned MAX_MESSAGE = wsd_pkg::MAX_MESSAGE_DEF,
    parameter int unsigned MAX_CONTROL = wsd_pkg::MAX_CONTROL_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_rx_byte,
    input  logic           i_allow,
    output wsd_pkg::t_burst o_burst
);
    import wsd_pkg::*;

    localparam int unsigned ML_W      = $clog2(MAX_MESSAGE + 1);
    localparam logic [15:0] MAX_MSG_L = 16'(MAX_MESSAGE);
    localparam logic [15:0] MAX_CTL_L = 16'(MAX_CONTROL);

    t_phase            r_phase,      n_phase;
    logic [3:0]        r_opcode,     n_opcode;
    logic              r_final,      n_final;
    logic [3:0]        r_hdr_cnt,    n_hdr_cnt;
    logic [15:0]       r_frame_len,  n_frame_len;
    logic              r_len_ovf,    n_len_ovf;
    logic [31:0]       r_mask_key,   n_mask_key;
    logic [ML_W-1:0]   r_pidx,       n_pidx;
    logic              r_msg_open,   n_msg_open;
    logic [ML_W-1:0]   r_msg_len,    n_msg_len;
    logic              r_closed,     n_closed;

    logic [15:0]       cand_len;
    logic              cand_ovf;
    logic              hd_big;
    logic              hd_ok;
    logic              hd_open;
    logic [ML_W-1:0]   hd_len;
    logic [16:0]       msg_sum;

    logic              hd_go;
    logic              fe_go;
    logic [3:0]        hc_dec;
    logic [3:0]        hc_inc;
    logic [ML_W-1:0]   pidx_inc;
    logic [7:0]        key_byte;
    logic [7:0]        plain;

    logic              e0_v;
    t_kind             e0_kind;
    logic              e1_v;
    t_kind             e1_kind;

    // Length as it stands once the byte that completes the length field is in
    assign cand_len = (r_phase == PH_SECOND) ? {9'd0, i_rx_byte[6:0]}
                                             : {r_frame_len[7:0], i_rx_byte};
    assign cand_ovf = (r_phase == PH_SECOND) ? 1'b0
                                             : (r_len_ovf | (r_frame_len[15:8] != 8'd0));

    assign hc_dec   = r_hdr_cnt - 4'd1;
    assign hc_inc   = r_hdr_cnt + 4'd1;
    assign pidx_inc = r_pidx + ML_W'(1);

    // Select the mask byte for this payload position
    always_comb begin
        case (r_pidx[1:0])
            2'd0:    key_byte = r_mask_key[31:24];
            2'd1:    key_byte = r_mask_key[23:16];
            2'd2:    key_byte = r_mask_key[15:8];
            default: key_byte = r_mask_key[7:0];
        endcase
    end
    assign plain = i_rx_byte ^ key_byte;

    // Check the header once the length is known
    always_comb begin
        hd_big  = cand_ovf || (cand_len > MAX_MSG_L);
        msg_sum = 17'(r_msg_len) + 17'(cand_len);
        hd_ok   = 1'b0;
        hd_open = r_msg_open;
        hd_len  = r_msg_len;
        case (r_opcode) inside
            OP_CONT: begin
                if (r_msg_open && (msg_sum <= 17'(MAX_MSG_L))) begin
                    hd_ok  = 1'b1;
                    hd_len = msg_sum[ML_W-1:0];
                end
            end
            OP_BINARY: begin
                if (!r_msg_open) begin
                    hd_ok = 1'b1;
                    if (!r_final) begin
                        hd_open = 1'b1;
                        hd_len  = cand_len[ML_W-1:0];
                    end
                end
            end
            OP_CLOSE, OP_PING, OP_PONG: begin
                hd_ok = r_final && (cand_len <= MAX_CTL_L);
            end
            default: hd_ok = 1'b0;
        endcase
    end

    // Advance the parser on each accepted byte
    always_comb begin
        n_phase     = r_phase;
        n_opcode    = r_opcode;
        n_final     = r_final;
        n_hdr_cnt   = r_hdr_cnt;
        n_frame_len = r_frame_len;
        n_len_ovf   = r_len_ovf;
        n_mask_key  = r_mask_key;
        n_pidx      = r_pidx;
        n_msg_open  = r_msg_open;
        n_msg_len   = r_msg_len;
        n_closed    = r_closed;
        hd_go       = 1'b0;
        fe_go       = 1'b0;
        e0_v        = 1'b0;
        e0_kind     = K_DATA;
        e1_v        = 1'b0;
        e1_kind     = K_ABORT;

        if (i_accept && !r_closed) begin
            unique case (r_phase)
                PH_FIRST: begin
                    if (i_rx_byte[6:4] != 3'd0) begin
                        e1_v     = 1'b1;
                        e1_kind  = K_ABORT;
                        n_closed = 1'b1;
                    end else begin
                        n_final  = i_rx_byte[7];
                        n_opcode = i_rx_byte[3:0];
                        n_phase  = PH_SECOND;
                    end
                end
                PH_SECOND: begin
                    if (!i_rx_byte[7]) begin
                        e1_v     = 1'b1;
                        e1_kind  = K_ABORT;
                        n_closed = 1'b1;
                        n_phase  = PH_FIRST;
                    end else begin
                        n_frame_len = 16'd0;
                        n_len_ovf   = 1'b0;
                        if (i_rx_byte[6:0] == LEN_CODE_16) begin
                            n_hdr_cnt = 4'd2;
                            n_phase   = PH_EXTLEN;
                        end else if (i_rx_byte[6:0] == LEN_CODE_64) begin
                            n_hdr_cnt = 4'd8;
                            n_phase   = PH_EXTLEN;
                        end else begin
                            n_frame_len = cand_len;
                            hd_go       = 1'b1;
                        end
                    end
                end
                PH_EXTLEN: begin
                    n_len_ovf   = cand_ovf;
                    n_frame_len = cand_len;
                    n_hdr_cnt   = hc_dec;
                    hd_go       = (hc_dec == 4'd0);
                end
                PH_MASK: begin
                    n_mask_key = {r_mask_key[23:0], i_rx_byte};
                    n_hdr_cnt  = hc_inc;
                    if (hc_inc >= 4'd4) begin
                        n_pidx = '0;
                        if (r_frame_len == 16'd0) fe_go = 1'b1;
                        else n_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    if ((r_opcode == OP_CONT) || (r_opcode == OP_BINARY)) begin
                        e0_v    = i_allow;
                        e0_kind = K_DATA;
                    end else if (r_opcode == OP_PING) begin
                        e0_v    = 1'b1;
                        e0_kind = K_PONG_BYTE;
                    end
                    n_pidx = pidx_inc;
                    fe_go  = (16'(pidx_inc) >= r_frame_len);
                end
                default: n_phase = PH_FIRST;
            endcase

            // Finish the header: close on oversize, drop on protocol error
            if (hd_go) begin
                if (hd_big) begin
                    e1_v     = 1'b1;
                    e1_kind  = K_CLOSE_1009;
                    n_closed = 1'b1;
                    n_phase  = PH_FIRST;
                end else if (!hd_ok) begin
                    e1_v     = 1'b1;
                    e1_kind  = K_ABORT;
                    n_closed = 1'b1;
                    n_phase  = PH_FIRST;
                end else begin
                    n_msg_open = hd_open;
                    n_msg_len  = hd_len;
                    n_phase    = PH_MASK;
                    n_hdr_cnt  = 4'd0;
                end
            end

            // Finish the frame: commit, close reply or pong send
            if (fe_go) begin
                n_phase = PH_FIRST;
                if ((r_opcode == OP_CONT) || (r_opcode == OP_BINARY)) begin
                    if (r_final) begin
                        e1_v       = i_allow;
                        e1_kind    = K_COMMIT;
                        n_msg_open = 1'b0;
                        n_msg_len  = '0;
                    end
                end else if (r_opcode == OP_CLOSE) begin
                    e1_v     = 1'b1;
                    e1_kind  = K_CLOSE;
                    n_closed = 1'b1;
                end else if (r_opcode == OP_PING) begin
                    e1_v    = 1'b1;
                    e1_kind = K_PONG_SEND;
                end
            end
        end
    end

    // Pack the results of this byte, the last one flagged
    always_comb begin
        o_burst       = '0;
        o_burst.count = {1'b0, e0_v} + {1'b0, e1_v};
        if (e0_v) begin
            o_burst.r0.kind        = e0_kind;
            o_burst.r0.data_byte   = plain;
            o_burst.r0.last_of_run = !e1_v;
            o_burst.r1.kind        = e1_kind;
            o_burst.r1.last_of_run = 1'b1;
        end else begin
            o_burst.r0.kind        = e1_kind;
            o_burst.r0.last_of_run = 1'b1;
        end
    end

    // Hold the parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_FIRST;
            r_opcode    <= 4'd0;
            r_final     <= 1'b0;
            r_hdr_cnt   <= 4'd0;
            r_frame_len <= 16'd0;
            r_len_ovf   <= 1'b0;
            r_mask_key  <= 32'd0;
            r_pidx      <= '0;
            r_msg_open  <= 1'b0;
            r_msg_len   <= '0;
            r_closed    <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_opcode    <= n_opcode;
            r_final     <= n_final;
            r_hdr_cnt   <= n_hdr_cnt;
            r_frame_len <= n_frame_len;
            r_len_ovf   <= n_len_ovf;
            r_mask_key  <= n_mask_key;
            r_pidx      <= n_pidx;
            r_msg_open  <= n_msg_open;
            r_msg_len   <= n_msg_len;
            r_closed    <= n_closed;
        end
    end

endmodule

### design/wsd_out_queue.sv
`timescale 1ns / 1ps
// Result queue: takes up to two results per cycle, hands out one per transfer.
// Depends on wsd_pkg.
module wsd_out_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  wsd_pkg::t_burst  i_burst,
    output logic             o_room,
    output logic             o_valid,
    input  logic             i_ready,
    output wsd_pkg::t_result o_item
);
    import wsd_pkg::*;

    t_result           r_entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count,  n_count;
    logic              pop;
    logic [QPTR_W-1:0] wr_next;

    // Leave room for a full burst
    assign o_room  = (r_count <= QCNT_W'(QUEUE_DEPTH - 2));
    assign o_valid = (r_count != '0);
    assign o_item  = r_entry[r_rd_ptr];
    assign pop     = o_valid && i_ready;
    assign wr_next = r_wr_ptr + QPTR_W'(1);

    // Advance pointers and count
    always_comb begin
        n_wr_ptr = r_wr_ptr + QPTR_W'(i_burst.count);
        n_rd_ptr = r_rd_ptr + QPTR_W'(pop);
        n_count  = r_count + QCNT_W'(i_burst.count) - QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the burst entries
    always_ff @(posedge i_clk) begin
        if (i_burst.count != 2'd0) r_entry[r_wr_ptr] <= i_burst.r0;
        if (i_burst.count == 2'd2) r_entry[wr_next]  <= i_burst.r1;
    end

endmodule

### design/websocket_client_frame_deframer_unit.sv
`timescale 1ns / 1ps
// Top level of the WebSocket client frame deframer: parser plus result queue.
// Depends on wsd_pkg, wsd_parser and wsd_out_queue.
//
//  channel   | handshake                | payload
//  ----------+--------------------------+------------------------------------
//  rx byte   | i_rx_valid / o_rx_ready  | i_rx_byte
//  results   | o_out_valid / i_out_ready| o_kind, o_data_byte, o_last_of_run
//  config    | i_cfg_we (no wait)       | i_cfg_wdata (allow_transmit)
//
// One received byte is taken per cycle; it is parsed in the cycle of its
// transfer and its zero to two results land in a four-entry queue.
// The output side moves one result per cycle while i_out_ready is high; a byte
// with two results (last byte plus commit or pong send) takes two transfers.
// o_rx_ready drops only when the queue has fewer than two free entries.
// Synchronous active-low reset; no clearing pass.
module websocket_client_frame_deframer_unit #(
    parameter int unsigned MAX_MESSAGE = wsd_pkg::MAX_MESSAGE_DEF,
    parameter int unsigned MAX_CONTROL = wsd_pkg::MAX_CONTROL_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_kind,
    output logic [7:0] o_data_byte,
    output logic       o_last_of_run
);
    import wsd_pkg::*;

    logic    r_allow;
    logic    rx_xfer;
    t_burst  burst;
    t_result head;

    // Hold the transmit enable
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_allow <= 1'b0;
        else if (i_cfg_we) r_allow <= i_cfg_wdata;
    end

    assign rx_xfer = i_rx_valid && o_rx_ready;

    wsd_parser #(
        .MAX_MESSAGE (MAX_MESSAGE),
        .MAX_CONTROL (MAX_CONTROL)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (rx_xfer),
        .i_rx_byte (i_rx_byte),
        .i_allow   (r_allow),
        .o_burst   (burst)
    );

    wsd_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_burst (burst),
        .o_room  (o_rx_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (head)
    );

    assign o_kind        = head.kind;
    assign o_data_byte   = head.data_byte;
    assign o_last_of_run = head.last_of_run;

endmodule

### design/wsd_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the deframer, bound to the top level.
// Depends on wsd_pkg and websocket_client_frame_deframer_unit.
module wsd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [2:0] o_kind,
    input logic [7:0] o_data_byte,
    input logic       o_last_of_run
);
    import wsd_pkg::*;

    logic out_xfer;
    logic is_shut;

    assign out_xfer = o_out_valid && i_out_ready;
    assign is_shut  = (o_kind == K_CLOSE) || (o_kind == K_CLOSE_1009) || (o_kind == K_ABORT);

    // Reset empties the result side
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // Hold a stalled result
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_kind) && $stable(o_data_byte) && $stable(o_last_of_run))
        else $error("stalled result changed");

    // Only data and pong bytes carry a byte
    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind != K_DATA) && (o_kind != K_PONG_BYTE) |-> o_data_byte == 8'd0)
        else $error("mark result carries a nonzero byte");

    // A shutdown result ends its run
    a_shut_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && is_shut |-> o_last_of_run)
        else $error("shutdown result not last of run");

    // Nothing follows a shutdown result
    a_shut_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && is_shut |=> !o_out_valid)
        else $error("result after shutdown");

endmodule

bind websocket_client_frame_deframer_unit wsd_checker u_wsd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_kind        (o_kind),
    .o_data_byte   (o_data_byte),
    .o_last_of_run (o_last_of_run)
);
